// ===== rtl/rec_pkg.sv =====
package rec_pkg;

	localparam int DEFAULT_ENTRIES = 32;

	localparam int OP_W     = 2;
	localparam int NUM_W    = 32;
	localparam int DEV_W    = 16;
	localparam int ENTRY_W  = 5;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 5;
	localparam int REF_W    = 16;

	localparam logic [REF_W-1:0] REFS_TOP = '1;

	typedef enum logic [OP_W-1:0] {
		OP_GET     = 2'd0,
		OP_ADD     = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT         = 3'd0,
		ST_CLAIMED     = 3'd1,
		ST_FULL        = 3'd2,
		ST_DONE        = 3'd3,
		ST_COUNT_ERROR = 3'd4
	} status_t;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [DEV_W-1:0] device;
		logic [REF_W-1:0] refs;
	} entry_t;

endpackage

// ===== rtl/rec_list_ram.sv =====
module rec_list_ram import rec_pkg::*; #(
	parameter int ENTRIES = DEFAULT_ENTRIES,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] raddr,
	output logic [IW-1:0] rdata,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [IW-1:0] wdata
);

	// A position never written holds its own index, which is the reset order.
	logic [IW-1:0]      mem [ENTRIES];
	logic [ENTRIES-1:0] written_q;
	logic [IW-1:0]      rdata_q;
	logic [IW-1:0]      raddr_q;
	logic               rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_q  <= 1'b0;
			raddr_q   <= '0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			rvalid_q <= written_q[raddr];
			raddr_q  <= raddr;
		end
	end

	assign rdata = rvalid_q ? rdata_q : raddr_q;

endmodule

// ===== rtl/rec_entry_ram.sv =====
module rec_entry_ram import rec_pkg::*; #(
	parameter int ENTRIES = DEFAULT_ENTRIES,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata
);

	// An entry never written reads as all zeros.
	entry_t             mem [ENTRIES];
	logic [ENTRIES-1:0] written_q;
	entry_t             rdata_q;
	logic               rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			rvalid_q <= written_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/rec_seq.sv =====
module rec_seq import rec_pkg::*; #(
	parameter int ENTRIES = DEFAULT_ENTRIES,
	localparam int IW = $clog2(ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [NUM_W-1:0]    key_number,
	input  logic [DEV_W-1:0]    key_device,
	input  logic [ENTRY_W-1:0]  entry,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [REF_W-1:0]    references,
	output logic [IW-1:0]       list_raddr,
	input  logic [IW-1:0]       list_rdata,
	output logic                list_we,
	output logic [IW-1:0]       list_waddr,
	output logic [IW-1:0]       list_wdata,
	output logic [IW-1:0]       ent_raddr,
	input  entry_t              ent_rdata,
	output logic                ent_we,
	output logic [IW-1:0]       ent_waddr,
	output entry_t              ent_wdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_GET_LIST,
		S_GET_ENTRY,
		S_GET_CMP,
		S_REF_READ,
		S_REF_UPD,
		S_FIND_READ,
		S_FIND_CHK,
		S_SHIFT_READ,
		S_SHIFT_WRITE,
		S_FRONT,
		S_RESULT
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEV_W-1:0]    dev_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       pos_q;
	logic                have_free_q;
	logic [IW-1:0]       free_q;
	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [REF_W-1:0]    res_refs_q;
	logic                rsp_valid_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [REF_W-1:0]    refs_q;

	logic                key_match;
	logic                is_free;
	logic                at_top;
	logic                last_pos;
	logic [IW-1:0]       free_sel;
	logic [REF_W-1:0]    refs_inc;
	logic [REF_W-1:0]    refs_dec;

	// The one compare unit, applied to whichever entry was read last.
	assign key_match = (ent_rdata.number == num_q) && (ent_rdata.device == dev_q);
	assign is_free   = (ent_rdata.refs == '0);
	assign at_top    = (ent_rdata.refs == REFS_TOP);
	assign refs_inc  = ent_rdata.refs + REF_W'(1);
	assign refs_dec  = ent_rdata.refs - REF_W'(1);
	assign last_pos  = (pos_q == IW'(ENTRIES - 1));
	assign free_sel  = is_free ? idx_q : free_q;

	assign list_raddr = (state_q == S_SHIFT_READ) ? pos_q - IW'(1) : pos_q;
	assign ent_raddr  = (state_q == S_GET_ENTRY) ? list_rdata : idx_q;

	always_comb begin
		list_we    = 1'b0;
		list_waddr = pos_q;
		list_wdata = list_rdata;
		ent_we     = 1'b0;
		ent_waddr  = idx_q;
		ent_wdata  = '{number: ent_rdata.number, device: ent_rdata.device, refs: refs_inc};
		case (state_q)
			S_SHIFT_WRITE: begin
				list_we = 1'b1;
			end
			S_FRONT: begin
				list_we    = 1'b1;
				list_waddr = '0;
				list_wdata = idx_q;
			end
			S_GET_CMP: begin
				if (key_match) begin
					ent_we = !at_top;
				end else if (last_pos && (have_free_q || is_free)) begin
					ent_we    = 1'b1;
					ent_waddr = free_sel;
					ent_wdata = '{number: num_q, device: dev_q, refs: REF_W'(1)};
				end
			end
			S_REF_UPD: begin
				if (op_q == OP_ADD) begin
					ent_we = !at_top;
				end else begin
					ent_we         = !is_free;
					ent_wdata.refs = refs_dec;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			num_q        <= '0;
			dev_q        <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			have_free_q  <= 1'b0;
			free_q       <= '0;
			res_status_q <= ST_HIT;
			res_slot_q   <= '0;
			res_refs_q   <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_HIT;
			slot_q       <= '0;
			refs_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_RESULT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q        <= op;
						num_q       <= key_number;
						dev_q       <= key_device;
						idx_q       <= IW'(entry);
						pos_q       <= '0;
						have_free_q <= 1'b0;
						if (op == OP_GET) begin
							state_q <= S_GET_LIST;
						end else if (op != OP_ADD && op != OP_RELEASE) begin
							res_status_q <= ST_COUNT_ERROR;
							res_slot_q   <= '0;
							res_refs_q   <= '0;
							state_q      <= S_RESULT;
						end else if (32'(entry) >= ENTRIES) begin
							res_status_q <= ST_COUNT_ERROR;
							res_slot_q   <= SLOT_W'(entry);
							res_refs_q   <= '0;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_REF_READ;
						end
					end
				end
				S_GET_LIST: begin
					state_q <= S_GET_ENTRY;
				end
				S_GET_ENTRY: begin
					idx_q   <= list_rdata;
					state_q <= S_GET_CMP;
				end
				S_GET_CMP: begin
					if (key_match) begin
						res_slot_q <= SLOT_W'(idx_q);
						if (at_top) begin
							res_status_q <= ST_COUNT_ERROR;
							res_refs_q   <= REFS_TOP;
						end else begin
							res_status_q <= ST_HIT;
							res_refs_q   <= refs_inc;
						end
						state_q <= S_RESULT;
					end else begin
						if (is_free) begin
							have_free_q <= 1'b1;
							free_q      <= idx_q;
						end
						if (last_pos) begin
							if (have_free_q || is_free) begin
								res_status_q <= ST_CLAIMED;
								res_slot_q   <= SLOT_W'(free_sel);
								res_refs_q   <= REF_W'(1);
							end else begin
								res_status_q <= ST_FULL;
								res_slot_q   <= '0;
								res_refs_q   <= '0;
							end
							state_q <= S_RESULT;
						end else begin
							pos_q   <= pos_q + IW'(1);
							state_q <= S_GET_LIST;
						end
					end
				end
				S_REF_READ: begin
					state_q <= S_REF_UPD;
				end
				S_REF_UPD: begin
					res_slot_q <= SLOT_W'(idx_q);
					state_q    <= S_RESULT;
					if (op_q == OP_ADD) begin
						if (at_top) begin
							res_status_q <= ST_COUNT_ERROR;
							res_refs_q   <= REFS_TOP;
						end else begin
							res_status_q <= ST_DONE;
							res_refs_q   <= refs_inc;
						end
					end else if (is_free) begin
						res_status_q <= ST_COUNT_ERROR;
						res_refs_q   <= '0;
					end else begin
						res_status_q <= ST_DONE;
						res_refs_q   <= refs_dec;
						if (refs_dec == '0) begin
							state_q <= S_FIND_READ;
						end
					end
				end
				S_FIND_READ: begin
					state_q <= S_FIND_CHK;
				end
				S_FIND_CHK: begin
					if (list_rdata == idx_q) begin
						state_q <= (pos_q == '0) ? S_RESULT : S_SHIFT_READ;
					end else begin
						pos_q   <= pos_q + IW'(1);
						state_q <= S_FIND_READ;
					end
				end
				S_SHIFT_READ: begin
					state_q <= S_SHIFT_WRITE;
				end
				S_SHIFT_WRITE: begin
					pos_q   <= pos_q - IW'(1);
					state_q <= (pos_q == IW'(1)) ? S_FRONT : S_SHIFT_READ;
				end
				S_FRONT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						status_q    <= res_status_q;
						slot_q      <= res_slot_q;
						refs_q      <= res_refs_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready  = (state_q == S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign references = refs_q;

endmodule

// ===== rtl/refcounted_entry_cache.sv =====
// Channel   Handshake              Beat contents
// request   req_valid / req_ready  op, key_number, key_device, entry
// response  rsp_valid / rsp_ready  status, slot, references
//
// One request is worked at a time; req_ready is high only while the sequencer is idle.
// A get scans the recency list through list and entry memories with one read and one
// write port each, in S_GET_LIST, S_GET_ENTRY and S_GET_CMP per position. An add or
// release passes S_REF_READ and S_REF_UPD. A release that frees an entry then finds it
// in the list (S_FIND_READ, S_FIND_CHK per position) and, unless it is at the front,
// shifts those ahead back (S_SHIFT_READ, S_SHIFT_WRITE) and puts it first (S_FRONT).
// Reset clears per-entry valid bits at once, so no clearing pass is needed.
// The response register lets a new request be taken while a finished beat waits.
module refcounted_entry_cache import rec_pkg::*; #(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [NUM_W-1:0]    key_number,
	input  logic [DEV_W-1:0]    key_device,
	input  logic [ENTRY_W-1:0]  entry,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [REF_W-1:0]    references
);

	localparam int IW = $clog2(ENTRIES);

	logic [IW-1:0] list_raddr;
	logic [IW-1:0] list_rdata;
	logic          list_we;
	logic [IW-1:0] list_waddr;
	logic [IW-1:0] list_wdata;
	logic [IW-1:0] ent_raddr;
	entry_t        ent_rdata;
	logic          ent_we;
	logic [IW-1:0] ent_waddr;
	entry_t        ent_wdata;

	rec_list_ram #(.ENTRIES(ENTRIES)) u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (list_raddr),
		.rdata  (list_rdata),
		.we     (list_we),
		.waddr  (list_waddr),
		.wdata  (list_wdata)
	);

	rec_entry_ram #(.ENTRIES(ENTRIES)) u_entries (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (ent_raddr),
		.rdata  (ent_rdata),
		.we     (ent_we),
		.waddr  (ent_waddr),
		.wdata  (ent_wdata)
	);

	rec_seq #(.ENTRIES(ENTRIES)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.op         (op),
		.key_number (key_number),
		.key_device (key_device),
		.entry      (entry),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.slot       (slot),
		.references (references),
		.list_raddr (list_raddr),
		.list_rdata (list_rdata),
		.list_we    (list_we),
		.list_waddr (list_waddr),
		.list_wdata (list_wdata),
		.ent_raddr  (ent_raddr),
		.ent_rdata  (ent_rdata),
		.ent_we     (ent_we),
		.ent_waddr  (ent_waddr),
		.ent_wdata  (ent_wdata)
	);

endmodule

// ===== rtl/rec_checker.sv =====
module rec_checker import rec_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [SLOT_W-1:0]   slot,
	input logic [REF_W-1:0]    references
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot)
			&& $stable(references))
		else $error("Response beat changed while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request taken while another is being worked.");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> slot == '0 && references == '0)
		else $error("Full response carries a slot or count.");

	a_claim_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_CLAIMED |-> references == REF_W'(1))
		else $error("Claimed entry does not hold a single reference.");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_HIT |-> references != '0)
		else $error("Hit reports a zero count.");

endmodule

bind refcounted_entry_cache rec_checker u_rec_checker (.*);

// ===== bench/refcounted_entry_cache_test.sv =====
typedef struct {
	rec_pkg::status_t            status;
	logic [rec_pkg::SLOT_W-1:0]  slot;
	logic [rec_pkg::REF_W-1:0]   references;
} cache_reply_t;

class refcount_board;
	localparam int SIZE = rec_pkg::DEFAULT_ENTRIES;

	logic [rec_pkg::NUM_W-1:0] key_number [SIZE];
	logic [rec_pkg::DEV_W-1:0] key_device [SIZE];
	logic [rec_pkg::REF_W-1:0] use_count [SIZE];
	int                        recency [SIZE];
	cache_reply_t              awaited [$];
	int                        failures;

	function new();
		for (int i = 0; i < SIZE; i++) begin
			key_number[i] = '0;
			key_device[i] = '0;
			use_count[i] = '0;
			recency[i] = i;
		end
		failures = 0;
	endfunction

	function void move_to_front(int idx);
		int p;
		p = 0;
		while (p < SIZE && recency[p] != idx)
			p++;
		for (int q = p; q > 0; q--)
			recency[q] = recency[q - 1];
		recency[0] = idx;
	endfunction

	function cache_reply_t lookup(logic [rec_pkg::NUM_W-1:0] num,
			logic [rec_pkg::DEV_W-1:0] dev);
		cache_reply_t r;
		int idx;
		int spare;
		spare = -1;
		for (int p = 0; p < SIZE; p++) begin
			idx = recency[p];
			if (key_number[idx] == num && key_device[idx] == dev) begin
				r.slot = rec_pkg::SLOT_W'(idx);
				if (use_count[idx] == rec_pkg::REFS_TOP) begin
					r.status = rec_pkg::ST_COUNT_ERROR;
					r.references = rec_pkg::REFS_TOP;
				end else begin
					use_count[idx] = use_count[idx] + rec_pkg::REF_W'(1);
					r.status = rec_pkg::ST_HIT;
					r.references = use_count[idx];
				end
				return r;
			end
			if (use_count[idx] == '0)
				spare = idx;
		end
		if (spare < 0) begin
			r.status = rec_pkg::ST_FULL;
			r.slot = '0;
			r.references = '0;
		end else begin
			key_number[spare] = num;
			key_device[spare] = dev;
			use_count[spare] = rec_pkg::REF_W'(1);
			r.status = rec_pkg::ST_CLAIMED;
			r.slot = rec_pkg::SLOT_W'(spare);
			r.references = rec_pkg::REF_W'(1);
		end
		return r;
	endfunction

	function void accept(logic [rec_pkg::OP_W-1:0] op, logic [rec_pkg::NUM_W-1:0] num,
			logic [rec_pkg::DEV_W-1:0] dev, logic [rec_pkg::ENTRY_W-1:0] ent);
		cache_reply_t r;
		int idx;
		idx = int'(ent);
		r.status = rec_pkg::ST_COUNT_ERROR;
		r.slot = '0;
		r.references = '0;
		case (op)
			rec_pkg::OP_GET: begin
				r = lookup(num, dev);
			end
			rec_pkg::OP_ADD: begin
				r.slot = ent;
				if (use_count[idx] == rec_pkg::REFS_TOP) begin
					r.references = rec_pkg::REFS_TOP;
				end else begin
					use_count[idx] = use_count[idx] + rec_pkg::REF_W'(1);
					r.status = rec_pkg::ST_DONE;
					r.references = use_count[idx];
				end
			end
			rec_pkg::OP_RELEASE: begin
				r.slot = ent;
				if (use_count[idx] != '0) begin
					use_count[idx] = use_count[idx] - rec_pkg::REF_W'(1);
					if (use_count[idx] == '0)
						move_to_front(idx);
					r.status = rec_pkg::ST_DONE;
					r.references = use_count[idx];
				end
			end
			default: begin
			end
		endcase
		awaited.push_back(r);
	endfunction

	function void check(logic [rec_pkg::STATUS_W-1:0] st, logic [rec_pkg::SLOT_W-1:0] sl,
			logic [rec_pkg::REF_W-1:0] rf);
		cache_reply_t e;
		if (awaited.size() == 0) begin
			$error("response beat with none awaited: status %0d slot %0d references %0d",
				st, sl, rf);
			failures++;
			return;
		end
		e = awaited.pop_front();
		if (st !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, st);
			failures++;
		end
		if (sl !== e.slot) begin
			$error("slot: expected %0d, got %0d", e.slot, sl);
			failures++;
		end
		if (rf !== e.references) begin
			$error("references: expected %0d, got %0d", e.references, rf);
			failures++;
		end
	endfunction
endclass

module refcounted_entry_cache_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rec_pkg::*;

	localparam int RANDOM_ITEMS = 1650;
	localparam int KEY_POOL = 40;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [ENTRY_W-1:0] PINNED_ENTRY = 5'd31;

	typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} traffic_mix_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [OP_W-1:0]     op = '0;
	logic [NUM_W-1:0]    key_number = '0;
	logic [DEV_W-1:0]    key_device = '0;
	logic [ENTRY_W-1:0]  entry = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [REF_W-1:0]    references;

	refcount_board board = new();
	logic [NUM_W-1:0] pool_number [KEY_POOL];
	logic [DEV_W-1:0] pool_device [KEY_POOL];
	int quiet_cycles = 0;

	refcounted_entry_cache uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.op(op),
		.key_number(key_number),
		.key_device(key_device),
		.entry(entry),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.slot(slot),
		.references(references)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				board.check(status, slot, references);
			if (req_valid && req_ready)
				board.accept(op, key_number, key_device, entry);
		end
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
		$display("refcounted_entry_cache: mismatch");
		$finish;
	end

	// The response side runs on its own: mostly ready, with short and long stalls.
	initial begin : response_sink
		int pick;
		int run;
		bit level;
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				level = 1'b1;
				run = (pick < 8) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			end else begin
				level = 1'b0;
				run = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			repeat (run) begin
				@(negedge clk);
				rsp_ready <= level;
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [ENTRY_W-1:0] held_entry(logic [ENTRY_W-1:0] fallback);
		int held [$];
		for (int i = 0; i < DEFAULT_ENTRIES; i++)
			if (board.use_count[i] != '0)
				held.push_back(i);
		if (held.size() == 0)
			return fallback;
		return ENTRY_W'(held[$urandom_range(0, held.size() - 1)]);
	endfunction

	task automatic hold_off(int gap);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_pause();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic offer(logic [OP_W-1:0] o, logic [NUM_W-1:0] nm, logic [DEV_W-1:0] dv,
			logic [ENTRY_W-1:0] en);
		req_valid <= 1'b1;
		op <= o;
		key_number <= nm;
		key_device <= dv;
		entry <= en;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic issue_random(traffic_mix_t mix);
		int roll;
		int get_share;
		int release_share;
		int k;
		logic [OP_W-1:0] o;
		logic [NUM_W-1:0] nm;
		logic [DEV_W-1:0] dv;
		logic [ENTRY_W-1:0] en;
		get_share = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 25 : 50;
		release_share = (mix == MIX_FILL) ? 50 : (mix == MIX_DRAIN) ? 80 : 60;
		nm = $urandom;
		dv = DEV_W'($urandom);
		en = ENTRY_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll >= 97) begin
			o = OP_UNUSED;
		end else if (roll < get_share) begin
			o = OP_GET;
			k = $urandom_range(0, KEY_POOL - 1);
			roll = $urandom_range(0, 9);
			if (roll < 7) begin
				nm = pool_number[k];
				dv = pool_device[k];
			end else if (roll < 9) begin
				nm = pool_number[k];
			end
		end else begin
			o = ($urandom_range(0, 99) < release_share) ? OP_RELEASE : OP_ADD;
			if ($urandom_range(0, 99) < 85)
				en = held_entry(en);
		end
		offer(o, nm, dv, en);
	endtask

	initial begin : stimulus
		traffic_mix_t mix;
		bit burst;
		mix = MIX_BALANCED;
		burst = 1'b0;
		pool_number[0] = '0;
		pool_device[0] = '0;
		pool_number[1] = '1;
		pool_device[1] = '1;
		for (int i = 2; i < KEY_POOL; i++) begin
			pool_number[i] = $urandom;
			pool_device[i] = DEV_W'($urandom);
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		hold_off(0); offer(OP_GET, '0, '0, '0);
		hold_off(0); offer(OP_GET, '1, '1, '1);
		hold_off(1); offer(OP_GET, '0, '1, 5'd3);
		hold_off(0); offer(OP_GET, '1, '0, 5'd28);
		hold_off(0); offer(OP_ADD, '1, '0, PINNED_ENTRY);
		hold_off(2); offer(OP_RELEASE, '0, '1, PINNED_ENTRY);
		hold_off(0); offer(OP_RELEASE, '0, '0, PINNED_ENTRY);
		hold_off(0); offer(OP_RELEASE, '1, '1, PINNED_ENTRY);
		hold_off(3); offer(OP_GET, '1, '1, '0);
		hold_off(0); offer(OP_UNUSED, '1, '1, '1);
		hold_off(0); offer(OP_UNUSED, '0, '0, '0);
		hold_off(0); offer(OP_RELEASE, 32'h5555_AAAA, 16'hA5A5, 5'd0);
		hold_off(0); offer(OP_ADD, 32'hAAAA_5555, 16'h5A5A, 5'd7);
		hold_off(1); offer(OP_GET, '0, '0, 5'd21);
		hold_off(0); offer(OP_GET, 32'h8000_0001, 16'h8001, 5'd10);
		hold_off(0); offer(OP_RELEASE, '0, '0, 5'd29);
		hold_off(5); offer(OP_GET, 32'h7FFF_FFFE, 16'h7FFE, 5'd16);
		hold_off(0); offer(OP_ADD, '0, '0, 5'd30);
		hold_off(0); offer(OP_RELEASE, '0, '0, 5'd30);
		hold_off(0); offer(OP_GET, '0, '1, 5'd30);
		hold_off(0); offer(OP_ADD, '0, '0, PINNED_ENTRY);
		hold_off(0); offer(OP_GET, '1, '1, '0);
		hold_off(0); offer(OP_RELEASE, '0, '0, PINNED_ENTRY);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				mix = traffic_mix_t'($urandom_range(0, 2));
				burst = ($urandom_range(0, 4) == 0);
			end
			if (n == RANDOM_ITEMS / 2)
				drain_pause();
			else
				hold_off(burst ? 0 : pick_gap());
			issue_random(mix);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("refcounted_entry_cache: match");
		else
			$display("refcounted_entry_cache: mismatch");
		$finish;
	end
endmodule
